FILE: rtl/arpr_pkg.sv
// ----------------------------------------------------------------------------
// arpr_pkg
// Shared types and constants for the ARP responder with neighbor cache.
// ----------------------------------------------------------------------------
package arpr_pkg;

   localparam int BKT_W      = 8;
   localparam int BUCKETS    = 1 << BKT_W;
   localparam int WAYS       = 4;
   localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam int IP_W       = 32;
   localparam int MAC_W      = 48;
   localparam int LEN_W      = 16;
   localparam int PTYPE_W    = 16;
   localparam int ALEN_W     = 8;
   localparam int OP_W       = 16;
   localparam int STATUS_W   = 3;

   localparam int APB_DATA_W = 64;
   localparam int APB_ADDR_W = 4;

   localparam logic [LEN_W-1:0]   MIN_ARP_LEN = 16'd28;
   localparam logic [PTYPE_W-1:0] PROTO_IPV4  = 16'h0800;
   localparam logic [ALEN_W-1:0]  MAC_LEN     = 8'd6;
   localparam logic [ALEN_W-1:0]  IPV4_LEN    = 8'd4;
   localparam logic [OP_W-1:0]    OP_REQUEST  = 16'd1;
   localparam logic [OP_W-1:0]    OP_REPLY    = 16'd2;

   localparam logic CMD_PACKET  = 1'b0;
   localparam logic CMD_LOOKUP  = 1'b1;

   localparam logic REG_OWN_IP  = 1'b0;
   localparam logic REG_OWN_MAC = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_SHORT       = 3'd1,
      ST_NOT_IPV4    = 3'd2,
      ST_BAD_HW_LEN  = 3'd3,
      ST_BAD_PR_LEN  = 3'd4,
      ST_BAD_OPCODE  = 3'd5,
      ST_NO_OWN_IP   = 3'd6,
      ST_NOT_FOR_US  = 3'd7
   } status_type;

   typedef logic [WAYS-1:0][IP_W-1:0]  ip_row_type;
   typedef logic [WAYS-1:0][MAC_W-1:0] mac_row_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                send_reply;
      logic [MAC_W-1:0]    reply_dest_mac;
      logic [IP_W-1:0]     reply_target_ip;
      logic                learned;
      logic                table_full;
      logic                lookup_hit;
      logic [MAC_W-1:0]    lookup_mac;
   } rsp_type;

endpackage

FILE: rtl/arpr_if.sv
// ----------------------------------------------------------------------------
// arpr_req_if / arpr_rsp_if
// Valid/ready channels for ARP packets and lookups, and for their results.
// ----------------------------------------------------------------------------
interface arpr_req_if;
   import arpr_pkg::*;

   logic               valid;
   logic               ready;
   logic               command;
   logic [LEN_W-1:0]   packet_length;
   logic [PTYPE_W-1:0] proto_type;
   logic [ALEN_W-1:0]  hw_len;
   logic [ALEN_W-1:0]  proto_len;
   logic [OP_W-1:0]    opcode;
   logic [MAC_W-1:0]   sender_mac;
   logic [IP_W-1:0]    sender_ip;
   logic [IP_W-1:0]    target_ip;
   logic [IP_W-1:0]    lookup_ip;

   modport source (
      output valid, command, packet_length, proto_type, hw_len, proto_len,
             opcode, sender_mac, sender_ip, target_ip, lookup_ip,
      input  ready
   );
   modport sink (
      input  valid, command, packet_length, proto_type, hw_len, proto_len,
             opcode, sender_mac, sender_ip, target_ip, lookup_ip,
      output ready
   );
endinterface

interface arpr_rsp_if;
   import arpr_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                send_reply;
   logic [MAC_W-1:0]    reply_dest_mac;
   logic [IP_W-1:0]     reply_target_ip;
   logic                learned;
   logic                table_full;
   logic                lookup_hit;
   logic [MAC_W-1:0]    lookup_mac;

   modport source (
      output valid, status, send_reply, reply_dest_mac, reply_target_ip,
             learned, table_full, lookup_hit, lookup_mac,
      input  ready
   );
   modport sink (
      input  valid, status, send_reply, reply_dest_mac, reply_target_ip,
             learned, table_full, lookup_hit, lookup_mac,
      output ready
   );
endinterface

FILE: rtl/arp_responder_with_cache.sv
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP packet checker and responder with a set-associative neighbor cache.
// ----------------------------------------------------------------------------
// req_chan carries a parsed ARP packet (command 0) or a cache lookup
// (command 1); every transfer yields exactly one transfer on rsp_chan.
// The APB port holds the own IPv4 address (0x0) and own MAC (0x8).
// Write it only while no item is in flight.
//
// Cache: BUCKETS rows of WAYS entries, indexed by the low bits of the IP,
// held in two single-port RAMs (IP row, MAC row) with registered reads.
// An item reads its row on the accepting edge; the compare state then checks,
// compares all ways and, once the output register is free, writes the row
// back on a learn while loading the result. One item is in work at a time:
// a new item is taken only after the last has left the compare state,
// since the bucket row is read and then written back.
//
// Reset clears the control and config registers and zeroes the IP RAM in a
// sweep, one row a cycle; req_chan.ready is low for all BUCKETS (256) rows.
// A stalled result holds in the output register; the item behind it waits
// in the compare stage with its row data held.
// ----------------------------------------------------------------------------
module arp_responder_with_cache (
   input  logic                                clock,
   input  logic                                reset,
   arpr_req_if.sink                            req_chan,
   arpr_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [arpr_pkg::APB_ADDR_W-1:0]     paddr,
   input  logic [arpr_pkg::APB_DATA_W-1:0]     pwdata,
   output logic [arpr_pkg::APB_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import arpr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EVAL = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic               clear_active_ff, clear_active_in;
   logic [BKT_W-1:0]   clear_addr_ff, clear_addr_in;

   logic [IP_W-1:0]    own_ip_ff;
   logic [MAC_W-1:0]   own_mac_ff;

   logic               cmd_ff;
   logic [LEN_W-1:0]   plen_bytes_ff;
   logic [PTYPE_W-1:0] ptype_ff;
   logic [ALEN_W-1:0]  hlen_ff;
   logic [ALEN_W-1:0]  plen_ff;
   logic [OP_W-1:0]    op_ff;
   logic [MAC_W-1:0]   smac_ff;
   logic [IP_W-1:0]    tip_ff;
   logic [IP_W-1:0]    key_ff;

   ip_row_type         ip_mem [BUCKETS];
   mac_row_type        mac_mem [BUCKETS];
   ip_row_type         ip_rd_ff;
   mac_row_type        mac_rd_ff;

   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               out_free;
   logic               complete;
   logic [IP_W-1:0]    rd_key;
   logic               cfg_write;

   logic [WAYS-1:0]    hit_vec, empty_vec;
   logic [WAY_W-1:0]   hit_way, empty_way, way_sel;
   logic               any_hit, any_empty;
   status_type         status_c;
   logic               learn_en, learned_c, full_c, reply_c;

   logic               ip_we, mac_we;
   logic [BKT_W-1:0]   ip_wr_addr;
   ip_row_type         ip_wr_row;
   mac_row_type        mac_wr_row;

   // configuration
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else if (cfg_write) begin
         case (paddr[APB_ADDR_W-1])
            REG_OWN_IP:  own_ip_ff  <= pwdata[IP_W-1:0];
            REG_OWN_MAC: own_mac_ff <= pwdata[MAC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[APB_ADDR_W-1])
         REG_OWN_IP:  prdata = {{(APB_DATA_W-IP_W){1'b0}}, own_ip_ff};
         REG_OWN_MAC: prdata = {{(APB_DATA_W-MAC_W){1'b0}}, own_mac_ff};
         default:     prdata = '0;
      endcase
   end

   // handshake
   assign req_chan.ready = (state_ff == S_IDLE) && !clear_active_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign complete       = (state_ff == S_EVAL) && out_free;
   assign rd_key         = (req_chan.command == CMD_LOOKUP) ? req_chan.lookup_ip
                                                            : req_chan.sender_ip;

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_chan.command;
         plen_bytes_ff <= req_chan.packet_length;
         ptype_ff      <= req_chan.proto_type;
         hlen_ff       <= req_chan.hw_len;
         plen_ff       <= req_chan.proto_len;
         op_ff         <= req_chan.opcode;
         smac_ff       <= req_chan.sender_mac;
         tip_ff        <= req_chan.target_ip;
         key_ff        <= rd_key;
      end
   end

   // bucket RAMs
   always_ff @(posedge clock) begin
      if (ip_we) begin
         ip_mem[ip_wr_addr] <= ip_wr_row;
      end
      if (mac_we) begin
         mac_mem[key_ff[BKT_W-1:0]] <= mac_wr_row;
      end
      if (accept) begin
         ip_rd_ff  <= ip_mem[rd_key[BKT_W-1:0]];
         mac_rd_ff <= mac_mem[rd_key[BKT_W-1:0]];
      end
   end

   // way compare
   always_comb begin
      hit_way   = '0;
      empty_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w]   = (ip_rd_ff[w] == key_ff) && (key_ff != '0);
         empty_vec[w] = (ip_rd_ff[w] == '0);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (empty_vec[w]) begin
            empty_way = WAY_W'(w);
         end
      end
      any_hit   = |hit_vec;
      any_empty = |empty_vec;
      way_sel   = any_hit ? hit_way : empty_way;
   end

   // packet checks
   always_comb begin
      if (plen_bytes_ff < MIN_ARP_LEN) begin
         status_c = ST_SHORT;
      end else if (ptype_ff != PROTO_IPV4) begin
         status_c = ST_NOT_IPV4;
      end else if (hlen_ff != MAC_LEN) begin
         status_c = ST_BAD_HW_LEN;
      end else if (plen_ff != IPV4_LEN) begin
         status_c = ST_BAD_PR_LEN;
      end else if (op_ff != OP_REQUEST && op_ff != OP_REPLY) begin
         status_c = ST_BAD_OPCODE;
      end else if (own_ip_ff == '0) begin
         status_c = ST_NO_OWN_IP;
      end else if (op_ff == OP_REQUEST && tip_ff != own_ip_ff) begin
         status_c = ST_NOT_FOR_US;
      end else begin
         status_c = ST_OK;
      end
   end

   assign learn_en  = (cmd_ff == CMD_PACKET) && (status_c == ST_OK) && (key_ff != '0);
   assign learned_c = learn_en && (any_hit || any_empty);
   assign full_c    = learn_en && !any_hit && !any_empty;
   assign reply_c   = (cmd_ff == CMD_PACKET) && (status_c == ST_OK) && (op_ff == OP_REQUEST);

   always_comb begin
      rsp_in = '0;
      if (cmd_ff == CMD_LOOKUP) begin
         rsp_in.status     = ST_OK;
         rsp_in.lookup_hit = any_hit;
         rsp_in.lookup_mac = any_hit ? mac_rd_ff[hit_way] : '0;
      end else begin
         rsp_in.status          = status_c;
         rsp_in.send_reply      = reply_c;
         rsp_in.reply_dest_mac  = reply_c ? smac_ff : '0;
         rsp_in.reply_target_ip = reply_c ? key_ff : '0;
         rsp_in.learned         = learned_c;
         rsp_in.table_full      = full_c;
      end
   end

   // write-back and reset sweep
   always_comb begin
      ip_wr_row           = ip_rd_ff;
      ip_wr_row[way_sel]  = key_ff;
      mac_wr_row          = mac_rd_ff;
      mac_wr_row[way_sel] = smac_ff;
      mac_we              = complete && learned_c;
      if (clear_active_ff) begin
         ip_we      = 1'b1;
         ip_wr_addr = clear_addr_ff;
         ip_wr_row  = '0;
      end else begin
         ip_we      = complete && learned_c;
         ip_wr_addr = key_ff[BKT_W-1:0];
      end
   end

   always_comb begin
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (clear_active_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == BKT_W'(BUCKETS - 1)) begin
            clear_active_in = 1'b0;
         end
      end
   end

   // control
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (complete) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.send_reply      = rsp_ff.send_reply;
   assign rsp_chan.reply_dest_mac  = rsp_ff.reply_dest_mac;
   assign rsp_chan.reply_target_ip = rsp_ff.reply_target_ip;
   assign rsp_chan.learned         = rsp_ff.learned;
   assign rsp_chan.table_full      = rsp_ff.table_full;
   assign rsp_chan.lookup_hit      = rsp_ff.lookup_hit;
   assign rsp_chan.lookup_mac      = rsp_ff.lookup_mac;

endmodule

FILE: rtl/arpr_checker.sv
// ----------------------------------------------------------------------------
// arpr_checker
// Port-level checks for the ARP responder, bound to the top level.
// ----------------------------------------------------------------------------
module arpr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [arpr_pkg::STATUS_W-1:0] status,
   input logic                          send_reply,
   input logic [arpr_pkg::MAC_W-1:0]    reply_dest_mac,
   input logic                          learned,
   input logic                          table_full,
   input logic                          lookup_hit,
   input logic [arpr_pkg::MAC_W-1:0]    lookup_mac
);
   import arpr_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(lookup_mac)
                                  && $stable(learned) && $stable(reply_dest_mac))
      else $error("stalled result changed");

   a_learn_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(learned && table_full))
      else $error("learned and table_full both set");

   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> !send_reply && !learned && !table_full
                                       && !lookup_hit && reply_dest_mac == '0)
      else $error("failed packet check with side effects");

   a_lookup_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && lookup_hit |-> status == ST_OK && !send_reply && !learned
                                  && !table_full)
      else $error("lookup hit mixed with packet fields");

   // reset sweep blocks input
   a_sweep: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("input ready during cache clear");

endmodule

bind arp_responder_with_cache arpr_checker u_arpr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .status         (rsp_chan.status),
   .send_reply     (rsp_chan.send_reply),
   .reply_dest_mac (rsp_chan.reply_dest_mac),
   .learned        (rsp_chan.learned),
   .table_full     (rsp_chan.table_full),
   .lookup_hit     (rsp_chan.lookup_hit),
   .lookup_mac     (rsp_chan.lookup_mac)
);
